// ----- design/mvbd_pkg.sv -----
// Shared types and constants for the majority-vote button debouncer.
`default_nettype none
package mvbd_pkg;

    localparam int NUM_BUTTONS = 9;
    localparam int PIN_W       = 9;
    localparam int BTN_W       = 4;
    localparam int THR_W       = 8;
    localparam int DMS_W       = 10;
    localparam int CFG_W       = 10;
    localparam int CNT_W       = 9;

    // Button indexes at or above this limit are rejected.
    localparam logic [BTN_W:0] BTN_LIMIT = (BTN_W + 1)'(NUM_BUTTONS);

    // Configuration register indexes.
    localparam logic REG_HALF_WINDOW = 1'b0;
    localparam logic REG_DEBOUNCE_MS = 1'b1;

    localparam logic [THR_W-1:0] THR_RESET = 8'd5;
    localparam logic [DMS_W-1:0] DMS_RESET = 10'd50;

    // Reported button state codes.
    localparam logic [1:0] ST_RELEASED = 2'd0;
    localparam logic [1:0] ST_PRESSED  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;

    typedef struct packed {
        logic             start_req;
        logic [BTN_W-1:0] button;
        logic [PIN_W-1:0] pin_levels;
    } in_t;

    typedef struct packed {
        logic       busy_res;
        logic       done_res;
        logic [1:0] button_state;
    } out_t;

endpackage
`default_nettype wire

// ----- design/mvbd_engine.sv -----
// Debounce state, configuration registers and per-tick step logic.
`default_nettype none
module mvbd_engine (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_addr,
    input  wire logic [mvbd_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire logic                             step,
    input  wire mvbd_pkg::in_t                    item,
    output mvbd_pkg::out_t                        result
);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_WIN1 = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_WIN2 = 4'b1000
    } phase_t;

    phase_t                            phase_reg, phase_next, ph_w;
    logic [mvbd_pkg::BTN_W-1:0]        sel_reg, sel_next, sel_w;
    logic [mvbd_pkg::CNT_W-1:0]        sc_reg, sc_next, sc_w, sc_inc;
    logic [mvbd_pkg::CNT_W-1:0]        hc_reg, hc_next, hc_w, hc_inc;
    logic [mvbd_pkg::DMS_W-1:0]        wc_reg, wc_next, wc_w, wc_inc;
    logic                              fv_reg, fv_next;
    logic [mvbd_pkg::THR_W-1:0]        thr_reg, thr_next;
    logic [mvbd_pkg::DMS_W-1:0]        dms_reg, dms_next;

    logic                              go_start, bad_start;
    logic [(2**mvbd_pkg::BTN_W)-1:0]   levels_ext;
    logic                              pin_bit;
    logic [mvbd_pkg::CNT_W-1:0]        win_size, lows;
    logic                              win_end, vote;

    // Config writes
    always_comb begin
        thr_next = thr_reg;
        dms_next = dms_reg;
        if (cfg_we) begin
            case (cfg_addr)
                mvbd_pkg::REG_HALF_WINDOW: thr_next = cfg_wdata[mvbd_pkg::THR_W-1:0];
                mvbd_pkg::REG_DEBOUNCE_MS: dms_next = cfg_wdata[mvbd_pkg::DMS_W-1:0];
                default: ;
            endcase
        end
    end

    assign bad_start = (phase_reg == PH_IDLE) && item.start_req &&
                       ({1'b0, item.button} >= mvbd_pkg::BTN_LIMIT);
    assign go_start  = (phase_reg == PH_IDLE) && item.start_req && !bad_start;

    // Working copy of state after a possible start
    assign ph_w  = go_start ? PH_WIN1 : phase_reg;
    assign sel_w = go_start ? item.button : sel_reg;
    assign sc_w  = go_start ? '0 : sc_reg;
    assign hc_w  = go_start ? '0 : hc_reg;
    assign wc_w  = go_start ? '0 : wc_reg;

    // Pins beyond the field read low
    assign levels_ext = {{((2**mvbd_pkg::BTN_W) - mvbd_pkg::PIN_W){1'b0}}, item.pin_levels};
    assign pin_bit    = levels_ext[sel_w];

    assign sc_inc   = sc_w + 1'b1;
    assign hc_inc   = hc_w + {{(mvbd_pkg::CNT_W-1){1'b0}}, pin_bit};
    assign wc_inc   = wc_w + 1'b1;
    assign win_size = (thr_reg == '0) ? 9'd2 : {thr_reg, 1'b0};
    assign win_end  = (sc_inc >= win_size);
    assign lows     = (sc_inc >= hc_inc) ? (sc_inc - hc_inc) : '0;
    assign vote     = !(hc_inc > lows);    // 1 = pressed, tie votes pressed

    always_comb begin
        phase_next = ph_w;
        sel_next   = sel_w;
        sc_next    = sc_w;
        hc_next    = hc_w;
        wc_next    = wc_w;
        fv_next    = fv_reg;
        result     = '0;
        case (ph_w)
            PH_IDLE: ;
            PH_WIN1: begin
                sc_next = sc_inc;
                hc_next = hc_inc;
                if (win_end) begin
                    fv_next    = vote;
                    sc_next    = '0;
                    hc_next    = '0;
                    wc_next    = '0;
                    phase_next = (dms_reg == '0) ? PH_WIN2 : PH_WAIT;
                end
            end
            PH_WAIT: begin
                wc_next = wc_inc;
                if (wc_inc >= dms_reg) begin
                    phase_next = PH_WIN2;
                end
            end
            PH_WIN2: begin
                sc_next = sc_inc;
                hc_next = hc_inc;
                if (win_end) begin
                    result.done_res     = 1'b1;
                    result.button_state = (vote != fv_reg) ? mvbd_pkg::ST_UNKNOWN :
                                          vote ? mvbd_pkg::ST_PRESSED :
                                                 mvbd_pkg::ST_RELEASED;
                    phase_next = PH_IDLE;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
        result.busy_res = (phase_next != PH_IDLE);
        if (bad_start) begin
            phase_next          = PH_IDLE;
            result.busy_res     = 1'b0;
            result.done_res     = 1'b1;
            result.button_state = mvbd_pkg::ST_UNKNOWN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            sel_reg   <= '0;
            sc_reg    <= '0;
            hc_reg    <= '0;
            wc_reg    <= '0;
            fv_reg    <= 1'b0;
            thr_reg   <= mvbd_pkg::THR_RESET;
            dms_reg   <= mvbd_pkg::DMS_RESET;
        end else begin
            thr_reg <= thr_next;
            dms_reg <= dms_next;
            if (step) begin
                phase_reg <= phase_next;
                sel_reg   <= sel_next;
                sc_reg    <= sc_next;
                hc_reg    <= hc_next;
                wc_reg    <= wc_next;
                fv_reg    <= fv_next;
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/majority_vote_button_debouncer.sv -----
// Top level of the majority-vote button debouncer: request registers around the step engine.
//
//  channel | ports                          | moves
//  --------+--------------------------------+---------------------------------------
//  input   | s_valid s_ready s_data         | one tick request: start, button, pins
//  result  | m_valid m_ready m_data         | one result per request: busy, done, state
//  config  | cfg_we cfg_addr cfg_wdata      | write half_window / debounce_ms
//
//  One request per clock while m_ready drains results; a request sits in the input register,
//  then in the result register. Each request is one step in mvbd_engine (counters and vote).
//  aresetn (synchronous, active low) clears state, the pipe and loads register defaults.
//  A stalled result holds its register; the input register still takes a request
//  whenever it is empty or moving on in the same cycle.
`default_nettype none
module majority_vote_button_debouncer (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire mvbd_pkg::in_t                s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output mvbd_pkg::out_t                    m_data,
    input  wire logic                         cfg_we,
    input  wire logic                         cfg_addr,
    input  wire logic [mvbd_pkg::CFG_W-1:0]   cfg_wdata
);

    logic            in_valid_reg, in_valid_next;
    mvbd_pkg::in_t   in_data_reg;
    logic            out_valid_reg, out_valid_next;
    mvbd_pkg::out_t  out_data_reg;
    mvbd_pkg::out_t  step_result;
    logic            advance;

    // A request steps the engine when the result register is free or draining.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    mvbd_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .item      (in_data_reg),
        .result    (step_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= step_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTH
    // A finished reading never reports itself still busy.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.done_res && m_data.busy_res))
        else $error("done and busy both set");

    // State field is zero unless a reading finishes.
    a_state_only_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.done_res) |-> (m_data.button_state == mvbd_pkg::ST_RELEASED))
        else $error("button_state set without done");

    // A stepped request always lands in the result register.
    a_step_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("stepped request lost");

    // A blocked request stays put in the input register.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)))
        else $error("blocked request changed");
`endif

endmodule
`default_nettype wire
